@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the branch predecode checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ design/ppcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppcbd_pkg
// Opcodes, result codes and the decoded-result type of the branch predecoder.
// ----------------------------------------------------------------------------
package ppcbd_pkg;

  // Primary and extended opcodes
  localparam logic [5:0] OpB     = 6'd18;
  localparam logic [5:0] OpBc    = 6'd16;
  localparam logic [5:0] OpXl    = 6'd19;
  localparam logic [9:0] XoRfi   = 10'd50;
  localparam logic [9:0] XoBclr  = 10'd16;
  localparam logic [9:0] XoBcctr = 10'd528;

  // BO bits that make a branch unconditional
  localparam logic [4:0] BoAlways = 5'h14;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_BRANCH  = 3'd1,
    KIND_COND    = 3'd2,
    KIND_CALL    = 3'd3,
    KIND_RETURN  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    MN_UNKNOWN = 4'd0,
    MN_B       = 4'd1,
    MN_BL      = 4'd2,
    MN_BC      = 4'd3,
    MN_BCL     = 4'd4,
    MN_RFI     = 4'd5,
    MN_BLR     = 4'd6,
    MN_BCLR    = 4'd7,
    MN_BCLRL   = 4'd8,
    MN_BCCTR   = 4'd9,
    MN_BCCTRL  = 4'd10
  } mnem_e;

  typedef enum logic [1:0] {
    REG_NONE = 2'd0,
    REG_LR   = 2'd1,
    REG_CTR  = 2'd2
  } reg_e;

  // Classification of one word, everything but the immediate target
  typedef struct packed {
    logic       is_branch;
    logic [4:0] cond_options;
    logic [4:0] cond_bit;
    logic       is_relative;
    logic       is_link;
    logic       is_interrupt_return;
    reg_e       reg_target;
    kind_e      kind;
    mnem_e      mnemonic_code;
  } dec_t;

  // Kind of a BO-controlled branch
  function automatic kind_e kind_for(logic [4:0] bo, logic lk);
    kind_e k;
    if ((bo & BoAlways) == BoAlways) begin
      k = lk ? KIND_CALL : KIND_BRANCH;
    end else begin
      k = KIND_COND;
    end
    return k;
  endfunction

endpackage

@@ design/ppcbd_target.sv @@
// ----------------------------------------------------------------------------
// ppcbd_target
// Immediate target computation: sign-extended displacement, absolute or
// added to the instruction address with wrap at 2^32.
// ----------------------------------------------------------------------------
module ppcbd_target import ppcbd_pkg::*; (
  input  logic [31:0] instr_word_i,
  input  logic [31:0] instr_addr_i,
  output logic [31:0] target_o
);

  logic [5:0]  op;
  logic [31:0] disp;
  logic        aa;

  assign op = instr_word_i[31:26];
  assign aa = instr_word_i[1];

  // Pick the displacement by opcode
  always_comb begin
    case (op)
      OpB:     disp = {{6{instr_word_i[25]}}, instr_word_i[25:2], 2'b00};
      OpBc:    disp = {{16{instr_word_i[15]}}, instr_word_i[15:2], 2'b00};
      default: disp = '0;
    endcase
  end

  // Absolute or address relative; zero where there is no immediate target
  always_comb begin
    if (op == OpB || op == OpBc) begin
      target_o = aa ? disp : instr_addr_i + disp;
    end else begin
      target_o = '0;
    end
  end

endmodule

@@ design/ppcbd_decode.sv @@
// ----------------------------------------------------------------------------
// ppcbd_decode
// Branch classification of one instruction word: kind, mnemonic, BO/BI,
// link and register-target flags.
// ----------------------------------------------------------------------------
module ppcbd_decode import ppcbd_pkg::*; (
  input  logic [31:0] instr_word_i,
  output dec_t        dec_o
);

  logic [5:0] op;
  logic [9:0] xo;
  logic [4:0] bo;
  logic [4:0] bi;
  logic       aa;
  logic       lk;

  assign op = instr_word_i[31:26];
  assign xo = instr_word_i[10:1];
  assign bo = instr_word_i[25:21];
  assign bi = instr_word_i[20:16];
  assign aa = instr_word_i[1];
  assign lk = instr_word_i[0];

  // Classify by primary opcode, then by extended opcode for the XL form
  always_comb begin
    dec_o = '0;
    unique case (op)
      OpB: begin
        dec_o.is_branch     = 1'b1;
        dec_o.is_relative   = ~aa;
        dec_o.is_link       = lk;
        dec_o.kind          = lk ? KIND_CALL : KIND_BRANCH;
        dec_o.mnemonic_code = lk ? MN_BL : MN_B;
      end
      OpBc: begin
        dec_o.is_branch     = 1'b1;
        dec_o.cond_options  = bo;
        dec_o.cond_bit      = bi;
        dec_o.is_relative   = ~aa;
        dec_o.is_link       = lk;
        dec_o.kind          = kind_for(bo, lk);
        dec_o.mnemonic_code = lk ? MN_BCL : MN_BC;
      end
      OpXl: begin
        dec_o.cond_options = bo;
        dec_o.cond_bit     = bi;
        if (xo == XoRfi && !lk) begin
          dec_o.is_branch           = 1'b1;
          dec_o.is_interrupt_return = 1'b1;
          dec_o.kind                = KIND_RETURN;
          dec_o.mnemonic_code       = MN_RFI;
        end else if (xo == XoBclr) begin
          dec_o.is_branch  = 1'b1;
          dec_o.is_link    = lk;
          dec_o.reg_target = REG_LR;
          // plain blr: unconditional, no link, BI clear
          if (!lk && (bo & BoAlways) == BoAlways && bi == 5'd0) begin
            dec_o.kind          = KIND_RETURN;
            dec_o.mnemonic_code = MN_BLR;
          end else begin
            dec_o.kind          = kind_for(bo, lk);
            dec_o.mnemonic_code = lk ? MN_BCLRL : MN_BCLR;
          end
        end else if (xo == XoBcctr) begin
          dec_o.is_branch     = 1'b1;
          dec_o.is_link       = lk;
          dec_o.reg_target    = REG_CTR;
          dec_o.kind          = kind_for(bo, lk);
          dec_o.mnemonic_code = lk ? MN_BCCTRL : MN_BCCTR;
        end
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule

@@ design/ppc_branch_predecode.sv @@
// ----------------------------------------------------------------------------
// ppc_branch_predecode
// PowerPC branch predecoder: classifies one instruction word per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive instr_word_i and instr_addr_i and raise start_i for one cycle per
//   word. A beat is taken at every rising edge with start_i high and busy_o
//   low; busy_o stays low, so a word can be taken in every cycle.
//   Each beat yields exactly one result, shown for one cycle with done_o
//   high, once it has passed the input register and then the result register.
//   Throughput is one word per cycle, set by the single decode and target
//   adder between the two registers.
//   The receiver cannot stall: it must take the result in the cycle done_o
//   is high.
//   Reset (rst_ni low, asynchronous) drops any beat in flight and clears
//   done_o; the word, address and result registers are not reset.
// ----------------------------------------------------------------------------
module ppc_branch_predecode import ppcbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] instr_addr_i,
  output logic        done_o,
  output logic        is_branch_o,
  output logic [31:0] target_o,
  output logic [4:0]  cond_options_o,
  output logic [4:0]  cond_bit_o,
  output logic        is_relative_o,
  output logic        is_link_o,
  output logic        is_interrupt_return_o,
  output logic [1:0]  reg_target_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  mnemonic_code_o
);

  logic        in_vld_q;
  logic [31:0] word_q;
  logic [31:0] addr_q;
  dec_t        dec_d;
  dec_t        dec_q;
  logic [31:0] target_d;
  logic [31:0] target_q;
  logic        done_q;

  // Never back-pressure the fetch side
  assign busy_o = 1'b0;

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      word_q <= instr_word_i;
      addr_q <= instr_addr_i;
    end
  end

  // Decode and compute the immediate target
  ppcbd_decode u_decode (
    .instr_word_i (word_q),
    .dec_o        (dec_d)
  );

  ppcbd_target u_target (
    .instr_word_i (word_q),
    .instr_addr_i (addr_q),
    .target_o     (target_d)
  );

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      dec_q    <= dec_d;
      target_q <= target_d;
    end
  end

  // Drive the result ports
  assign done_o                = done_q;
  assign is_branch_o           = dec_q.is_branch;
  assign target_o              = target_q;
  assign cond_options_o        = dec_q.cond_options;
  assign cond_bit_o            = dec_q.cond_bit;
  assign is_relative_o         = dec_q.is_relative;
  assign is_link_o             = dec_q.is_link;
  assign is_interrupt_return_o = dec_q.is_interrupt_return;
  assign reg_target_o          = dec_q.reg_target;
  assign kind_o                = dec_q.kind;
  assign mnemonic_code_o       = dec_q.mnemonic_code;

endmodule

@@ design/ppcbd_checker.sv @@
// ----------------------------------------------------------------------------
// ppcbd_checker
// Port-level checks of the branch predecoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppcbd_checker import ppcbd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        is_branch_o,
  input logic [31:0] target_o,
  input logic        is_relative_o,
  input logic        is_link_o,
  input logic        is_interrupt_return_o,
  input logic [1:0]  reg_target_o,
  input logic [2:0]  kind_o,
  input logic [3:0]  mnemonic_code_o
);

  logic beat;
  logic unknown_clean;
  logic rfi_shape;
  logic no_imm;

  // Input handshake and result shapes, evaluated combinationally
  assign beat          = start_i && !busy_o;
  assign unknown_clean = target_o == 32'd0 && !is_relative_o && !is_link_o &&
                         !is_interrupt_return_o && reg_target_o == REG_NONE &&
                         kind_o == KIND_UNKNOWN && mnemonic_code_o == MN_UNKNOWN;
  assign rfi_shape     = is_branch_o && kind_o == KIND_RETURN &&
                         mnemonic_code_o == MN_RFI && !is_link_o &&
                         reg_target_o == REG_NONE;
  assign no_imm        = target_o == 32'd0 && !is_relative_o;

  // Every accepted beat gives one result, after the input and result registers
  `ASSERT_NEXT(a_beat_to_result, clk_i, rst_ni, beat, ##1 done_o)

  // No result without an accepted beat
  `ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, done_o && $past(rst_ni, 2), $past(beat, 2))

  // An unrecognized word carries no flags, target or codes
  `ASSERT_IMPLY(a_unknown_clean, clk_i, rst_ni, done_o && !is_branch_o, unknown_clean)

  // rfi is a return without link or register target
  `ASSERT_IMPLY(a_rfi_shape, clk_i, rst_ni, done_o && is_interrupt_return_o, rfi_shape)

  // Register branches have no immediate target
  `ASSERT_IMPLY(a_reg_no_imm, clk_i, rst_ni, done_o && reg_target_o != REG_NONE, no_imm)

endmodule

bind ppc_branch_predecode ppcbd_checker u_ppcbd_checker (.*);

@@ dv/ppc_branch_predecode_tb.sv @@
// ----------------------------------------------------------------------------
// ppc_branch_predecode_tb
// Self-checking bench for the PowerPC branch predecoder.
// A queue of instruction words with addresses feeds a driver that issues one
// beat per cycle with random gaps. Every taken beat is decoded by a local
// model, and each done_o strobe is checked in order against those decodes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_branch_predecode_tb;
  import ppcbd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 1600;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxReports = 10;

  // Decoded view of one word, in port order
  typedef struct packed {
    logic        is_branch;
    logic [31:0] target;
    logic [4:0]  cond_options;
    logic [4:0]  cond_bit;
    logic        is_relative;
    logic        is_link;
    logic        is_iret;
    reg_e        reg_target;
    kind_e       kind;
    mnem_e       mnemonic;
  } branch_info_t;

  typedef struct {
    logic [31:0] word;
    logic [31:0] addr;
    bit          drain_first;
    bit          no_gap;
  } fetch_beat_t;

  typedef struct {
    logic [31:0]  word;
    branch_info_t info;
  } decode_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] instr_word_i = '0;
  logic [31:0] instr_addr_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        is_branch_o;
  logic [31:0] target_o;
  logic [4:0]  cond_options_o;
  logic [4:0]  cond_bit_o;
  logic        is_relative_o;
  logic        is_link_o;
  logic        is_interrupt_return_o;
  logic [1:0]  reg_target_o;
  logic [2:0]  kind_o;
  logic [3:0]  mnemonic_code_o;

  fetch_beat_t fetch_q[$];
  decode_exp_t decode_q[$];
  logic        beat_taken = 1'b0;
  int unsigned num_beats = 0;
  int unsigned beats_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  ppc_branch_predecode u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .instr_word_i         (instr_word_i),
    .instr_addr_i         (instr_addr_i),
    .done_o               (done_o),
    .is_branch_o          (is_branch_o),
    .target_o             (target_o),
    .cond_options_o       (cond_options_o),
    .cond_bit_o           (cond_bit_o),
    .is_relative_o        (is_relative_o),
    .is_link_o            (is_link_o),
    .is_interrupt_return_o(is_interrupt_return_o),
    .reg_target_o         (reg_target_o),
    .kind_o               (kind_o),
    .mnemonic_code_o      (mnemonic_code_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decode one word the way the predecoder should
  function automatic branch_info_t predecode_word(logic [31:0] word, logic [31:0] addr);
    branch_info_t d;
    logic [31:0]  disp;
    logic         aa;
    logic         lk;
    logic         always_taken;
    logic [4:0]   bo;
    logic [4:0]   bi;
    logic [9:0]   xo;
    d            = '0;
    d.reg_target = REG_NONE;
    d.kind       = KIND_UNKNOWN;
    d.mnemonic   = MN_UNKNOWN;
    aa           = word[1];
    lk           = word[0];
    bo           = word[25:21];
    bi           = word[20:16];
    xo           = word[10:1];
    always_taken = (bo & BoAlways) == BoAlways;
    case (word[31:26])
      OpB: begin
        disp          = {{6{word[25]}}, word[25:2], 2'b00};
        d.is_branch   = 1'b1;
        d.target      = aa ? disp : addr + disp;
        d.is_relative = !aa;
        d.is_link     = lk;
        d.kind        = lk ? KIND_CALL : KIND_BRANCH;
        d.mnemonic    = lk ? MN_BL : MN_B;
      end
      OpBc: begin
        disp           = {{16{word[15]}}, word[15:2], 2'b00};
        d.is_branch    = 1'b1;
        d.target       = aa ? disp : addr + disp;
        d.cond_options = bo;
        d.cond_bit     = bi;
        d.is_relative  = !aa;
        d.is_link      = lk;
        d.kind         = !always_taken ? KIND_COND : (lk ? KIND_CALL : KIND_BRANCH);
        d.mnemonic     = lk ? MN_BCL : MN_BC;
      end
      OpXl: begin
        // BO and BI show up for every opcode 19 word, recognized or not
        d.cond_options = bo;
        d.cond_bit     = bi;
        if (xo == XoRfi && !lk) begin
          d.is_branch = 1'b1;
          d.is_iret   = 1'b1;
          d.kind      = KIND_RETURN;
          d.mnemonic  = MN_RFI;
        end else if (xo == XoBclr) begin
          d.is_branch  = 1'b1;
          d.is_link    = lk;
          d.reg_target = REG_LR;
          if (!lk && always_taken && bi == 5'd0) begin
            d.kind     = KIND_RETURN;
            d.mnemonic = MN_BLR;
          end else begin
            d.kind     = !always_taken ? KIND_COND : (lk ? KIND_CALL : KIND_BRANCH);
            d.mnemonic = lk ? MN_BCLRL : MN_BCLR;
          end
        end else if (xo == XoBcctr) begin
          d.is_branch  = 1'b1;
          d.is_link    = lk;
          d.reg_target = REG_CTR;
          d.kind       = !always_taken ? KIND_COND : (lk ? KIND_CALL : KIND_BRANCH);
          d.mnemonic   = lk ? MN_BCCTRL : MN_BCCTR;
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  // Random word, biased toward the branch opcodes
  function automatic logic [31:0] rand_branch_word();
    logic [31:0] w;
    logic [4:0]  bo;
    int unsigned pick;
    w    = $urandom();
    pick = $urandom_range(99);
    bo   = w[25:21];
    if ($urandom_range(2) == 0) bo = bo | BoAlways;
    if (pick < 28) begin
      w[31:26] = OpB;
    end else if (pick < 52) begin
      w[31:26] = OpBc;
      w[25:21] = bo;
    end else if (pick < 90) begin
      w[31:26] = OpXl;
      w[25:21] = bo;
      case ($urandom_range(4))
        0: w[10:1] = XoBclr;
        1: w[10:1] = XoBcctr;
        2: w[10:1] = XoRfi;
        3: ;
        default: begin
          // aim at plain blr
          w[25:21] = bo | BoAlways;
          w[20:16] = 5'd0;
          w[10:1]  = XoBclr;
          w[0]     = ($urandom_range(3) == 0);
        end
      endcase
    end
    return w;
  endfunction

  function automatic logic [31:0] rand_fetch_addr();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(5))
      0: a = {16'h0000, a[15:0]};
      1: a = {6'h3F, a[25:0]};
      2: a = {16'hFFFF, a[15:0]};
      default: ;
    endcase
    return a;
  endfunction

  task automatic queue_beat(logic [31:0] word, logic [31:0] addr, bit drain_first, bit no_gap);
    fetch_beat_t b;
    b.word        = word;
    b.addr        = addr;
    b.drain_first = drain_first;
    b.no_gap      = no_gap;
    fetch_q.push_back(b);
  endtask

  // Issue beats at the falling edge; hold a beat until it is taken
  always @(negedge clk_i) begin : drive
    fetch_beat_t b;
    logic        issue;
    issue = 1'b0;
    if (rst_ni && !(start_i && !beat_taken)) begin
      if (fetch_q.size() > 0) begin
        if (fetch_q[0].drain_first && decode_q.size() != 0) begin
          issue = 1'b0;
        end else if (!fetch_q[0].no_gap && $urandom_range(99) < 19) begin
          issue = 1'b0;
        end else begin
          issue = 1'b1;
        end
      end
      if (issue) begin
        b = fetch_q.pop_front();
        instr_word_i <= b.word;
        instr_addr_i <= b.addr;
      end
      start_i <= issue;
    end
  end

  // Record taken beats, then check each strobed result against the oldest decode
  always @(posedge clk_i) begin : observe
    decode_exp_t  e;
    branch_info_t got;
    beat_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      e.word = instr_word_i;
      e.info = predecode_word(instr_word_i, instr_addr_i);
      decode_q.push_back(e);
      beats_taken++;
    end
    if (rst_ni && done_o) begin
      got.is_branch    = is_branch_o;
      got.target       = target_o;
      got.cond_options = cond_options_o;
      got.cond_bit     = cond_bit_o;
      got.is_relative  = is_relative_o;
      got.is_link      = is_link_o;
      got.is_iret      = is_interrupt_return_o;
      got.reg_target   = reg_e'(reg_target_o);
      got.kind         = kind_e'(kind_o);
      got.mnemonic     = mnem_e'(mnemonic_code_o);
      if (decode_q.size() == 0) begin
        if (err_cnt < MaxReports) begin
          $display("[%0t] result with no beat outstanding: target %h kind %0d mnem %0d",
                   $realtime, target_o, kind_o, mnemonic_code_o);
        end
        err_cnt++;
      end else begin
        e = decode_q.pop_front();
        if (got !== e.info) begin
          if (err_cnt < MaxReports) begin
            $display("[%0t] word %h mismatch (exp / got):", $realtime, e.word);
            $display("  br %b/%b tgt %h/%h bo %h/%h bi %h/%h rel %b/%b lk %b/%b",
                     e.info.is_branch, got.is_branch, e.info.target, got.target,
                     e.info.cond_options, got.cond_options, e.info.cond_bit, got.cond_bit,
                     e.info.is_relative, got.is_relative, e.info.is_link, got.is_link);
            $display("  iret %b/%b reg %0d/%0d kind %0d/%0d mnem %0d/%0d",
                     e.info.is_iret, got.is_iret, e.info.reg_target, got.reg_target,
                     e.info.kind, got.kind, e.info.mnemonic, got.mnemonic);
          end
          err_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    // Directed words: displacement extremes, every mnemonic, and the corner cases
    queue_beat(32'h0000_0000, 32'h0000_0000, 0, 0);
    queue_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    queue_beat({OpB, 24'h7F_FFFF, 2'b00}, 32'hFFFF_FF00, 0, 0);
    queue_beat({OpB, 24'h80_0000, 2'b00}, 32'h0000_0010, 0, 0);
    queue_beat({OpB, 24'h80_0001, 2'b10}, 32'h1234_5678, 0, 0);
    queue_beat({OpB, 24'h00_0004, 2'b01}, 32'h8000_0000, 0, 0);
    queue_beat({OpB, 24'hFF_FFFF, 2'b11}, 32'hFFFF_FFFC, 0, 0);
    queue_beat({OpBc, 5'h14, 5'h1F, 14'h1FFF, 2'b00}, 32'hFFFF_FFF0, 0, 0);
    queue_beat({OpBc, 5'h14, 5'h00, 14'h2000, 2'b01}, 32'h0000_0000, 0, 0);
    queue_beat({OpBc, 5'h04, 5'h02, 14'h0010, 2'b10}, 32'h0000_4000, 0, 0);
    queue_beat({OpBc, 5'h10, 5'h1F, 14'h3FFF, 2'b11}, 32'h7FFF_FFFF, 0, 0);
    queue_beat({OpBc, 5'h1F, 5'h0A, 14'h2000, 2'b10}, 32'hA5A5_5A5A, 0, 0);
    queue_beat({OpXl, 5'h14, 5'h00, 5'h00, XoBclr, 1'b0}, 32'h0000_1000, 0, 0);
    queue_beat({OpXl, 5'h1F, 5'h00, 5'h1F, XoBclr, 1'b0}, 32'hFFFF_FFFF, 0, 0);
    queue_beat({OpXl, 5'h14, 5'h01, 5'h00, XoBclr, 1'b0}, 32'h0000_1000, 0, 0);
    queue_beat({OpXl, 5'h14, 5'h00, 5'h00, XoBclr, 1'b1}, 32'h0000_1000, 0, 0);
    queue_beat({OpXl, 5'h0C, 5'h00, 5'h00, XoBclr, 1'b0}, 32'h0000_1000, 0, 0);
    queue_beat({OpXl, 5'h00, 5'h00, 5'h00, XoRfi, 1'b0}, 32'h0000_2000, 0, 0);
    queue_beat({OpXl, 5'h1F, 5'h1F, 5'h00, XoRfi, 1'b1}, 32'h0000_2000, 0, 0);
    queue_beat({OpXl, 5'h14, 5'h00, 5'h00, XoBcctr, 1'b0}, 32'h0000_3000, 0, 0);
    queue_beat({OpXl, 5'h04, 5'h1F, 5'h00, XoBcctr, 1'b1}, 32'h0000_3000, 0, 0);
    queue_beat({OpXl, 5'h1B, 5'h15, 5'h00, 10'd0, 1'b1}, 32'hDEAD_BEEF, 0, 0);
    queue_beat({OpXl, 5'h1F, 5'h1F, 5'h1F, 10'h3FF, 1'b0}, 32'hDEAD_BEEF, 0, 0);
    queue_beat({6'd31, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 0, 0);
    queue_beat({6'd17, 26'h3FF_FFFF}, 32'h0000_0000, 0, 0);

    // Random words; drain the pipe now and then, and run a stretch with no gaps
    for (int i = 0; i < NumRandom; i++) begin
      queue_beat(rand_branch_word(), rand_fetch_addr(), (i % 500) == 0,
                 i >= 700 && i < 1000);
    end
    num_beats = fetch_q.size();

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every beat to be taken and every result to come back
    while (beats_taken < num_beats || decode_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_cnt == 0 && decode_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
